FILE: src/cbcps_pkg.sv
// Package for the CPU bus cycle pin sequencer.
// Holds item and state types, pin masks and bus operation codes.
// No dependencies.
`timescale 1ns / 1ps

package cbcps_pkg;

    // Active-low control pin masks
    localparam logic [7:0] PIN_M1    = 8'h01;
    localparam logic [7:0] PIN_MREQ  = 8'h02;
    localparam logic [7:0] PIN_IORQ  = 8'h04;
    localparam logic [7:0] PIN_RD    = 8'h08;
    localparam logic [7:0] PIN_WR    = 8'h10;
    localparam logic [7:0] PIN_RFSH  = 8'h20;
    localparam logic [7:0] PIN_HALT  = 8'h40;
    localparam logic [7:0] PIN_BUSAK = 8'h80;

    // Pin levels after reset: M1 and HALT low, all others high
    localparam logic [7:0] PINS_RESET = 8'd190;

    // Bus operation codes
    localparam logic [2:0] OP_FETCH     = 3'd1;
    localparam logic [2:0] OP_FETCH_INT = 3'd2;
    localparam logic [2:0] OP_MEM_RD    = 3'd3;
    localparam logic [2:0] OP_MEM_WR    = 3'd4;
    localparam logic [2:0] OP_IO_RD     = 3'd5;
    localparam logic [2:0] OP_IO_WR     = 3'd6;

    // T-state numbers
    localparam logic [2:0] T1 = 3'd1;
    localparam logic [2:0] T2 = 3'd2;
    localparam logic [2:0] T3 = 3'd3;
    localparam logic [2:0] T4 = 3'd4;
    localparam logic [2:0] T5 = 3'd5;

    localparam logic [7:0] HALT_OPCODE = 8'h76;

    // bus_ctl and status_flags bit positions
    localparam int CTL_ACK = 0;
    localparam int CTL_REQ = 1;
    localparam int CTL_RST = 2;
    localparam int ST_NMI  = 0;
    localparam int ST_INT  = 1;
    localparam int ST_IFF1 = 2;
    localparam int ST_UNPF = 3;

    typedef struct packed {
        logic        edge_req;
        logic [2:0]  t_state;
        logic        wait_state;
        logic [2:0]  bus_op;
        logic [2:0]  prev_bus_op;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [2:0]  bus_ctl;
        logic [7:0]  refresh_count;
        logic [7:0]  opcode;
        logic [3:0]  status_flags;
        logic [7:0]  data_bus_in;
    } item_t;

    typedef struct packed {
        logic [15:0] address_bus;
        logic        address_drive;
        logic [7:0]  data_bus_out;
        logic        data_drive;
        logic [7:0]  control_pins;
        logic [7:0]  read_data;
        logic        read_valid;
        logic [7:0]  refresh_next;
    } result_t;

    // Latched bus state
    typedef struct packed {
        logic [15:0] address_latch;
        logic [7:0]  data_out_latch;
        logic        data_out_enable;
        logic [7:0]  pin_levels;
        logic        bus_released;
        logic [7:0]  sampled_data;
    } bus_state_t;

    localparam bus_state_t STATE_RESET = '{
        address_latch:   16'd0,
        data_out_latch:  8'd0,
        data_out_enable: 1'b0,
        pin_levels:      PINS_RESET,
        bus_released:    1'b0,
        sampled_data:    8'd0
    };

endpackage

FILE: src/cbcps_if.sv
// Handshake channel interfaces for the bus cycle pin sequencer.
// Depends on cbcps_pkg for the payload types.
`timescale 1ns / 1ps

interface cbcps_item_if;
    logic              valid;
    logic              ready;
    cbcps_pkg::item_t  item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface cbcps_result_if;
    logic               valid;
    logic               ready;
    cbcps_pkg::result_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

FILE: src/cpu_bus_cycle_pin_sequencer.sv
// Top level of the CPU bus cycle pin sequencer.
// Depends on cbcps_pkg, cbcps_if (channel interfaces) and cbcps_step.
`timescale 1ns / 1ps

// Each input item is one clock half-edge of the CPU bus. The block takes one
// item per cycle while the result side does not stall, and presents one result
// item for each accepted item: the item is held in an input register, the pin,
// address, data and drive latches are updated in one pass through the step
// logic, and the result lands in an output register. A stall on the result
// side holds the input register, and the input stays ready while the output
// register can take the next result. interrupt_page is written through
// cfg_write / cfg_data and supplies the high byte of the refresh address; the
// user must write it only while no items are in flight, as the block itself
// does not enforce this.
module cpu_bus_cycle_pin_sequencer
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [7:0]             cfg_data,
    cbcps_item_if.sink             cycle,
    cbcps_result_if.source         result
);

    logic                  in_valid_reg;
    cbcps_pkg::item_t      in_item_reg;
    logic                  out_valid_reg;
    cbcps_pkg::result_t    out_item_reg;
    cbcps_pkg::bus_state_t state_reg;
    cbcps_pkg::bus_state_t state_next;
    cbcps_pkg::result_t    step_result;
    logic [7:0]            page_reg;
    logic                  out_free;
    logic                  advance;

    // Handshake control
    assign out_free    = !out_valid_reg || result.ready;
    assign advance     = in_valid_reg && out_free;
    assign cycle.ready = !in_valid_reg || out_free;

    // Interrupt page register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            page_reg <= 8'd0;
        else if (cfg_write)
            page_reg <= cfg_data;
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (cycle.ready)
            in_valid_reg <= cycle.valid;
    end

    always_ff @(posedge clk)
    begin
        if (cycle.ready && cycle.valid)
            in_item_reg <= cycle.item;
    end

    // One half-edge of pin sequencing
    cbcps_step u_step
    (
        .item           (in_item_reg),
        .state_cur      (state_reg),
        .interrupt_page (page_reg),
        .state_next     (state_next),
        .result         (step_result)
    );

    // Bus latches
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= cbcps_pkg::STATE_RESET;
        else if (advance)
            state_reg <= state_next;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_item_reg <= step_result;
    end

    assign result.valid = out_valid_reg;
    assign result.item  = out_item_reg;

endmodule

FILE: src/cbcps_step.sv
// Next-state and result logic for one clock half-edge.
// Purely combinational; depends on cbcps_pkg.
`timescale 1ns / 1ps

module cbcps_step
(
    input  cbcps_pkg::item_t      item,
    input  cbcps_pkg::bus_state_t state_cur,
    input  logic [7:0]            interrupt_page,
    output cbcps_pkg::bus_state_t state_next,
    output cbcps_pkg::result_t    result
);

    logic       ack;
    logic       req;
    logic       rst;
    logic       fetch;
    logic       prev_fetch;
    logic       prev_write;
    logic       valid;
    logic [7:0] r;
    logic [7:0] r_next;
    logic [2:0] op;
    logic [3:0] st;
    cbcps_pkg::bus_state_t s;

    assign ack        = item.bus_ctl[cbcps_pkg::CTL_ACK];
    assign req        = item.bus_ctl[cbcps_pkg::CTL_REQ];
    assign rst        = item.bus_ctl[cbcps_pkg::CTL_RST];
    assign op         = item.bus_op;
    assign st         = item.status_flags;
    assign r          = item.refresh_count;
    assign fetch      = (op == cbcps_pkg::OP_FETCH) || (op == cbcps_pkg::OP_FETCH_INT);
    assign prev_fetch = (item.prev_bus_op == cbcps_pkg::OP_FETCH)
                     || (item.prev_bus_op == cbcps_pkg::OP_FETCH_INT);
    assign prev_write = (item.prev_bus_op == cbcps_pkg::OP_MEM_WR)
                     || (item.prev_bus_op == cbcps_pkg::OP_IO_WR);

    // Pin sequencing, applied in the order the bus cycle defines
    always_comb
    begin
        s      = state_cur;
        r_next = r;
        valid  = 1'b0;

        if (!item.edge_req)
        begin
            // rising edge: release, reclaim, then T-state actions
            if ((ack || rst) && !s.bus_released)
            begin
                s.pin_levels      = s.pin_levels & ~cbcps_pkg::PIN_BUSAK;
                s.bus_released    = 1'b1;
                s.data_out_enable = 1'b0;
            end
            if (!ack && !rst)
            begin
                if (s.bus_released)
                begin
                    s.bus_released    = 1'b0;
                    s.data_out_enable = 1'b0;
                end
                unique case (item.t_state)
                    cbcps_pkg::T1:
                    begin
                        if (!item.wait_state)
                        begin
                            s.address_latch = item.address;
                            if (prev_write)
                                s.data_out_enable = 1'b0;
                            if (fetch)
                                s.pin_levels = s.pin_levels & ~cbcps_pkg::PIN_M1;
                            if (prev_fetch)
                                s.pin_levels = s.pin_levels | cbcps_pkg::PIN_RFSH;
                        end
                    end
                    cbcps_pkg::T2:
                    begin
                        if (item.wait_state)
                        begin
                            if (op == cbcps_pkg::OP_IO_RD)
                                s.pin_levels = s.pin_levels
                                             & ~(cbcps_pkg::PIN_IORQ | cbcps_pkg::PIN_RD);
                            if (op == cbcps_pkg::OP_IO_WR)
                                s.pin_levels = s.pin_levels
                                             & ~(cbcps_pkg::PIN_IORQ | cbcps_pkg::PIN_WR);
                        end
                    end
                    cbcps_pkg::T3:
                    begin
                        // refresh address goes out, R counts in its low 7 bits
                        if (fetch)
                        begin
                            s.pin_levels    = (s.pin_levels | cbcps_pkg::PIN_M1)
                                            & ~cbcps_pkg::PIN_RFSH;
                            s.address_latch = {interrupt_page, r};
                            r_next          = {r[7], r[6:0] + 7'd1};
                        end
                        if (op == cbcps_pkg::OP_FETCH)
                            s.pin_levels = s.pin_levels
                                         | cbcps_pkg::PIN_MREQ | cbcps_pkg::PIN_RD;
                        if (op == cbcps_pkg::OP_FETCH_INT)
                            s.pin_levels = s.pin_levels | cbcps_pkg::PIN_IORQ;
                    end
                    cbcps_pkg::T5:
                    begin
                        if (fetch)
                        begin
                            s.address_latch = item.address;
                            s.pin_levels    = s.pin_levels | cbcps_pkg::PIN_RFSH;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        else if (!ack)
        begin
            // falling edge with the bus still ours
            unique case (item.t_state)
                cbcps_pkg::T1:
                begin
                    if (!item.wait_state)
                    begin
                        // RD low on a fetch here is kept as the bus file has it
                        if (op == cbcps_pkg::OP_FETCH || op == cbcps_pkg::OP_MEM_RD)
                            s.pin_levels = s.pin_levels
                                         & ~(cbcps_pkg::PIN_MREQ | cbcps_pkg::PIN_RD);
                        if (op == cbcps_pkg::OP_MEM_WR)
                            s.pin_levels = s.pin_levels & ~cbcps_pkg::PIN_MREQ;
                        if (op == cbcps_pkg::OP_MEM_WR || op == cbcps_pkg::OP_IO_WR)
                        begin
                            s.data_out_latch  = item.write_data;
                            s.data_out_enable = 1'b1;
                        end
                    end
                end
                cbcps_pkg::T2:
                begin
                    if (!item.wait_state)
                    begin
                        if (op == cbcps_pkg::OP_FETCH_INT)
                            s.pin_levels = s.pin_levels & ~cbcps_pkg::PIN_IORQ;
                        if (op == cbcps_pkg::OP_MEM_WR)
                            s.pin_levels = s.pin_levels & ~cbcps_pkg::PIN_WR;
                    end
                end
                cbcps_pkg::T3:
                begin
                    if (op == cbcps_pkg::OP_MEM_RD || op == cbcps_pkg::OP_IO_RD)
                    begin
                        s.sampled_data = item.data_bus_in;
                        valid          = 1'b1;
                    end
                    // MREQ low again during refresh, kept as given
                    if (fetch)
                        s.pin_levels = s.pin_levels & ~cbcps_pkg::PIN_MREQ;
                    if (op == cbcps_pkg::OP_MEM_RD)
                        s.pin_levels = s.pin_levels | cbcps_pkg::PIN_MREQ | cbcps_pkg::PIN_RD;
                    if (op == cbcps_pkg::OP_MEM_WR)
                        s.pin_levels = s.pin_levels | cbcps_pkg::PIN_MREQ | cbcps_pkg::PIN_WR;
                    if (op == cbcps_pkg::OP_IO_RD)
                        s.pin_levels = s.pin_levels | cbcps_pkg::PIN_IORQ | cbcps_pkg::PIN_RD;
                    if (op == cbcps_pkg::OP_IO_WR)
                        s.pin_levels = s.pin_levels | cbcps_pkg::PIN_IORQ | cbcps_pkg::PIN_WR;
                end
                cbcps_pkg::T4:
                begin
                    if (fetch)
                        s.pin_levels = s.pin_levels | cbcps_pkg::PIN_MREQ;
                    if (item.opcode == cbcps_pkg::HALT_OPCODE && st[cbcps_pkg::ST_UNPF])
                        s.pin_levels = s.pin_levels & ~cbcps_pkg::PIN_HALT;
                    if (st[cbcps_pkg::ST_NMI]
                        || (st[cbcps_pkg::ST_INT] && st[cbcps_pkg::ST_IFF1]))
                        s.pin_levels = s.pin_levels | cbcps_pkg::PIN_HALT;
                end
                default:
                begin
                end
            endcase
        end
        else if (!req)
        begin
            // bus handed back: BUSAK returns high
            s.pin_levels = s.pin_levels | cbcps_pkg::PIN_BUSAK;
        end
    end

    assign state_next = s;

    // Result item taken from the updated latches
    always_comb
    begin
        result.address_bus   = s.address_latch;
        result.address_drive = ~s.bus_released;
        result.data_bus_out  = s.data_out_latch;
        result.data_drive    = s.data_out_enable;
        result.control_pins  = s.pin_levels;
        result.read_data     = s.sampled_data;
        result.read_valid    = valid;
        result.refresh_next  = r_next;
    end

endmodule

FILE: dv/cpu_bus_cycle_pin_sequencer_tb.sv
// Self-checking testbench for the CPU bus cycle pin sequencer.
// Drives clock half-edge items, predicts every latched pin, drive and data result, and
// checks them in order. Depends on cbcps_pkg, cbcps_if and cpu_bus_cycle_pin_sequencer.
`timescale 1ns / 1ps

module cpu_bus_cycle_pin_sequencer_tb;

    import cbcps_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    // Edge, bus control, status and unused codes used by the stimulus
    localparam logic       RISE = 1'b0;
    localparam logic       FALL = 1'b1;
    localparam logic [2:0] CTL_IDLE     = 3'b000;
    localparam logic [2:0] CTL_ACK_ONLY = 3'(1 << CTL_ACK);
    localparam logic [2:0] CTL_GRANT    = 3'((1 << CTL_ACK) | (1 << CTL_REQ));
    localparam logic [2:0] CTL_RESET    = 3'(1 << CTL_RST);
    localparam logic [3:0] ST_NONE        = 4'd0;
    localparam logic [3:0] ST_HALT_READY  = 4'(1 << ST_UNPF);
    localparam logic [3:0] ST_NMI_HALT    = 4'((1 << ST_UNPF) | (1 << ST_NMI));
    localparam logic [3:0] ST_INT_ENABLED = 4'((1 << ST_INT) | (1 << ST_IFF1));
    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam logic [2:0] T_IDLE = 3'd0;
    localparam logic [2:0] T6     = 3'd6;
    localparam logic [2:0] T7     = 3'd7;

    logic       clk;
    logic       rst_n;
    logic       cfg_write;
    logic [7:0] cfg_data;

    cbcps_item_if   cycle_if ();
    cbcps_result_if result_if ();

    cpu_bus_cycle_pin_sequencer DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .cycle     (cycle_if),
        .result    (result_if)
    );

    // Predicted bus latches and I register
    bus_state_t modelled_bus;
    logic [7:0] modelled_page;

    item_t   pending_edges [$];
    result_t expected_pin_results [$];

    int  queued_edges;
    int  mismatch_count;
    int  cycle_count;
    int  send_pause;
    int  recv_pause;
    int  send_pace;
    int  recv_pace;
    int  sent_count;
    int  recv_count;
    logic edge_taken;
    logic result_taken;

    // Context of the machine cycle being generated
    logic [15:0] gen_addr;
    logic [7:0]  gen_wdata;
    logic [7:0]  gen_r;
    logic [7:0]  gen_din;
    logic [7:0]  gen_opc;
    logic [3:0]  gen_st;
    logic [2:0]  gen_prev;

    // Clock, 2 ns period
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Pin helpers for the prediction
    function automatic void pins_low(logic [7:0] mask);
        modelled_bus.pin_levels = modelled_bus.pin_levels & ~mask;
    endfunction

    function automatic void pins_high(logic [7:0] mask);
        modelled_bus.pin_levels = modelled_bus.pin_levels | mask;
    endfunction

    // Advance the bus latches by one clock half-edge and return what the block shows
    function automatic result_t predict_bus_edge(item_t e);
        result_t    res;
        logic       ack;
        logic       req;
        logic       rst;
        logic       fetch;
        logic       sampled;
        logic [7:0] r_next;
        ack     = e.bus_ctl[CTL_ACK];
        req     = e.bus_ctl[CTL_REQ];
        rst     = e.bus_ctl[CTL_RST];
        fetch   = (e.bus_op == OP_FETCH) || (e.bus_op == OP_FETCH_INT);
        r_next  = e.refresh_count;
        sampled = 1'b0;
        if (e.edge_req == RISE)
        begin
            // release first, then reclaim and per-T-state strobes
            if ((ack || rst) && !modelled_bus.bus_released)
            begin
                pins_low(PIN_BUSAK);
                modelled_bus.bus_released    = 1'b1;
                modelled_bus.data_out_enable = 1'b0;
            end
            if (!ack && !rst)
            begin
                if (modelled_bus.bus_released)
                begin
                    modelled_bus.bus_released    = 1'b0;
                    modelled_bus.data_out_enable = 1'b0;
                end
                case (e.t_state)
                    T1:
                    begin
                        if (!e.wait_state)
                        begin
                            modelled_bus.address_latch = e.address;
                            if (e.prev_bus_op == OP_MEM_WR || e.prev_bus_op == OP_IO_WR)
                                modelled_bus.data_out_enable = 1'b0;
                            if (fetch)
                                pins_low(PIN_M1);
                            if (e.prev_bus_op == OP_FETCH || e.prev_bus_op == OP_FETCH_INT)
                                pins_high(PIN_RFSH);
                        end
                    end
                    T2:
                    begin
                        if (e.wait_state)
                        begin
                            if (e.bus_op == OP_IO_RD)
                                pins_low(PIN_IORQ | PIN_RD);
                            if (e.bus_op == OP_IO_WR)
                                pins_low(PIN_IORQ | PIN_WR);
                        end
                    end
                    T3:
                    begin
                        // refresh address and R bump, bit 7 kept
                        if (fetch)
                        begin
                            pins_high(PIN_M1);
                            pins_low(PIN_RFSH);
                            modelled_bus.address_latch = {modelled_page, e.refresh_count};
                            r_next = {e.refresh_count[7], e.refresh_count[6:0] + 7'd1};
                        end
                        if (e.bus_op == OP_FETCH)
                            pins_high(PIN_MREQ | PIN_RD);
                        if (e.bus_op == OP_FETCH_INT)
                            pins_high(PIN_IORQ);
                    end
                    T5:
                    begin
                        if (fetch)
                        begin
                            modelled_bus.address_latch = e.address;
                            pins_high(PIN_RFSH);
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        else if (!ack)
        begin
            case (e.t_state)
                T1:
                begin
                    if (!e.wait_state)
                    begin
                        // fetch also drops RD here, as the original sequence does
                        if (e.bus_op == OP_FETCH || e.bus_op == OP_MEM_RD)
                            pins_low(PIN_MREQ | PIN_RD);
                        if (e.bus_op == OP_MEM_WR)
                            pins_low(PIN_MREQ);
                        if (e.bus_op == OP_MEM_WR || e.bus_op == OP_IO_WR)
                        begin
                            modelled_bus.data_out_latch  = e.write_data;
                            modelled_bus.data_out_enable = 1'b1;
                        end
                    end
                end
                T2:
                begin
                    if (!e.wait_state)
                    begin
                        if (e.bus_op == OP_FETCH_INT)
                            pins_low(PIN_IORQ);
                        if (e.bus_op == OP_MEM_WR)
                            pins_low(PIN_WR);
                    end
                end
                T3:
                begin
                    if (e.bus_op == OP_MEM_RD || e.bus_op == OP_IO_RD)
                    begin
                        modelled_bus.sampled_data = e.data_bus_in;
                        sampled = 1'b1;
                    end
                    // MREQ low again on a fetch: kept as the original sequence has it
                    if (fetch)
                        pins_low(PIN_MREQ);
                    if (e.bus_op == OP_MEM_RD)
                        pins_high(PIN_MREQ | PIN_RD);
                    if (e.bus_op == OP_MEM_WR)
                        pins_high(PIN_MREQ | PIN_WR);
                    if (e.bus_op == OP_IO_RD)
                        pins_high(PIN_IORQ | PIN_RD);
                    if (e.bus_op == OP_IO_WR)
                        pins_high(PIN_IORQ | PIN_WR);
                end
                T4:
                begin
                    if (fetch)
                        pins_high(PIN_MREQ);
                    if (e.opcode == HALT_OPCODE && e.status_flags[ST_UNPF])
                        pins_low(PIN_HALT);
                    if (e.status_flags[ST_NMI] || (e.status_flags[ST_INT] && e.status_flags[ST_IFF1]))
                        pins_high(PIN_HALT);
                end
                default:
                begin
                end
            endcase
        end
        else if (!req)
        begin
            pins_high(PIN_BUSAK);
        end
        res.address_bus   = modelled_bus.address_latch;
        res.address_drive = !modelled_bus.bus_released;
        res.data_bus_out  = modelled_bus.data_out_latch;
        res.data_drive    = modelled_bus.data_out_enable;
        res.control_pins  = modelled_bus.pin_levels;
        res.read_data     = modelled_bus.sampled_data;
        res.read_valid    = sampled;
        res.refresh_next  = r_next;
        return res;
    endfunction

    function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Per-item wait: none, full range, or mostly none with the odd long one
    function automatic int draw_pause(int pace);
        case (pace)
            0:       return 0;
            1:       return $urandom_range(0, 16);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
        endcase
    endfunction

    // Result check first, then prediction of the item taken at this edge
    always @(posedge clk)
    begin : check_and_predict
        result_t want;
        if (!rst_n)
        begin
            edge_taken   <= 1'b0;
            result_taken <= 1'b0;
        end
        else
        begin
            edge_taken   <= cycle_if.valid && cycle_if.ready;
            result_taken <= result_if.valid && result_if.ready;
            if (result_if.valid && result_if.ready)
            begin
                if (expected_pin_results.size() == 0)
                begin
                    $error("result item arrived with no expectation waiting");
                    mismatch_count++;
                end
                else
                begin
                    want = expected_pin_results.pop_front();
                    compare_field("address_bus", want.address_bus, result_if.item.address_bus);
                    compare_field("address_drive", want.address_drive,
                                  result_if.item.address_drive);
                    compare_field("data_bus_out", want.data_bus_out, result_if.item.data_bus_out);
                    compare_field("data_drive", want.data_drive, result_if.item.data_drive);
                    compare_field("control_pins", want.control_pins, result_if.item.control_pins);
                    compare_field("read_data", want.read_data, result_if.item.read_data);
                    compare_field("read_valid", want.read_valid, result_if.item.read_valid);
                    compare_field("refresh_next", want.refresh_next, result_if.item.refresh_next);
                end
            end
            if (cycle_if.valid && cycle_if.ready)
                expected_pin_results.push_back(predict_bus_edge(cycle_if.item));
        end
    end

    // Edge driver: presents queued items with a random gap after each
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!cycle_if.valid || edge_taken)
            begin
                if (send_pause > 0)
                begin
                    cycle_if.valid <= 1'b0;
                    send_pause--;
                end
                else if (pending_edges.size() > 0)
                begin
                    cycle_if.valid <= 1'b1;
                    cycle_if.item  <= pending_edges.pop_front();
                    send_pause = draw_pause(send_pace);
                    sent_count++;
                    if (sent_count % 64 == 0)
                        send_pace = $urandom_range(0, 2);
                end
                else
                begin
                    cycle_if.valid <= 1'b0;
                end
            end
        end
    end

    // Result sink: stalls a random number of cycles before each item
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (result_taken)
            begin
                recv_pause = draw_pause(recv_pace);
                recv_count++;
                if (recv_count % 64 == 0)
                    recv_pace = $urandom_range(0, 2);
            end
            if (recv_pause > 0)
            begin
                result_if.ready <= 1'b0;
                recv_pause--;
            end
            else
            begin
                result_if.ready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic void enqueue_edge(item_t e);
        pending_edges.push_back(e);
        queued_edges++;
    endfunction

    function automatic void push_edge(logic fall, logic [2:0] t, logic wt, logic [2:0] op,
                                      logic [2:0] prev, logic [2:0] ctl, logic [7:0] opc,
                                      logic [3:0] st);
        item_t e;
        e.edge_req      = fall;
        e.t_state       = t;
        e.wait_state    = wt;
        e.bus_op        = op;
        e.prev_bus_op   = prev;
        e.address       = gen_addr;
        e.write_data    = gen_wdata;
        e.bus_ctl       = ctl;
        e.refresh_count = gen_r;
        e.opcode        = opc;
        e.status_flags  = st;
        e.data_bus_in   = gen_din;
        enqueue_edge(e);
    endfunction

    // Both edges of one T-state; now and then an edge gets a stray bus control code
    function automatic void queue_t_state(logic [2:0] t, logic wt, logic [2:0] op,
                                          logic [2:0] ctl);
        for (int f = 0; f < 2; f++)
        begin
            gen_din = 8'($urandom);
            push_edge(1'(f), t, wt, op, gen_prev,
                      ($urandom_range(0, 39) == 0) ? 3'($urandom) : ctl, gen_opc, gen_st);
        end
    endfunction

    // A well-formed machine cycle with random content and wait states after T2
    function automatic void queue_machine_cycle();
        int         pick;
        int         last_t;
        int         waits;
        logic [2:0] op;
        logic       fetch;
        pick  = $urandom_range(0, 8);
        op    = (pick < 3) ? OP_FETCH : 3'(pick - 2);
        fetch = (op == OP_FETCH) || (op == OP_FETCH_INT);
        gen_addr  = 16'($urandom);
        gen_wdata = 8'($urandom);
        gen_opc   = ($urandom_range(0, 7) == 0) ? HALT_OPCODE : 8'($urandom);
        gen_st    = 4'($urandom);
        if ($urandom_range(0, 15) == 0)
            gen_r = 8'($urandom);
        last_t = fetch ? (($urandom_range(0, 2) == 0) ? 5 : 4) : 3;
        if (op == OP_IO_RD || op == OP_IO_WR)
            waits = $urandom_range(1, 2);
        else if (op == OP_FETCH_INT)
            waits = 2;
        else
            waits = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        for (int t = 1; t <= last_t; t++)
        begin
            queue_t_state(3'(t), 1'b0, op, CTL_IDLE);
            if (t == 2)
                for (int w = 0; w < waits; w++)
                    queue_t_state(T2, 1'b1, op, CTL_IDLE);
        end
        if (fetch)
            gen_r = {gen_r[7], gen_r[6:0] + 7'd1};
        gen_prev = op;
    endfunction

    // Bus handed over (or reset held) for a few T-states; a grant is then given back
    function automatic void queue_bus_handover();
        logic [2:0] hold_ctl;
        int         held;
        int         drop;
        hold_ctl = ($urandom_range(0, 2) == 0) ? CTL_RESET : CTL_GRANT;
        held     = $urandom_range(1, 4);
        drop     = $urandom_range(1, 2);
        for (int i = 0; i < held; i++)
            queue_t_state(3'($urandom), 1'($urandom), 3'($urandom), hold_ctl);
        if (hold_ctl == CTL_GRANT)
            for (int i = 0; i < drop; i++)
                queue_t_state(3'($urandom), 1'($urandom), 3'($urandom), CTL_ACK_ONLY);
    endfunction

    // Raw random items over the full field ranges
    function automatic void queue_noise();
        logic [95:0] raw;
        int          n;
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
        begin
            raw = {$urandom, $urandom, $urandom};
            enqueue_edge(raw[65:0]);
        end
    endfunction

    function automatic void queue_random_phase(int count);
        int goal;
        int pick;
        goal = queued_edges + count;
        while (queued_edges < goal)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 15)
                queue_machine_cycle();
            else if (pick < 17)
                queue_bus_handover();
            else
                queue_noise();
        end
    endfunction

    // Directed edges: field extremes, every operation and the corner cases
    function automatic void queue_directed();
        gen_addr  = 16'hFFFF;
        gen_wdata = 8'hFF;
        gen_r     = 8'hFF;
        gen_din   = 8'hFF;
        // fetch, incl. RD low at T1 falling, MREQ low again at T3 falling, HALT at T4
        push_edge(RISE, T1, 1'b0, OP_FETCH, OP_MEM_WR, CTL_IDLE, 8'h00, ST_NONE);
        push_edge(FALL, T1, 1'b0, OP_FETCH, OP_MEM_WR, CTL_IDLE, 8'h00, ST_NONE);
        push_edge(RISE, T3, 1'b0, OP_FETCH, OP_MEM_WR, CTL_IDLE, 8'h00, ST_NONE);
        push_edge(FALL, T3, 1'b0, OP_FETCH, OP_MEM_WR, CTL_IDLE, 8'h00, ST_NONE);
        push_edge(FALL, T4, 1'b0, OP_FETCH, OP_MEM_WR, CTL_IDLE, HALT_OPCODE, ST_HALT_READY);
        push_edge(RISE, T5, 1'b0, OP_FETCH, OP_MEM_WR, CTL_IDLE, 8'h00, ST_NONE);
        // memory write after a fetch: RFSH back high, data latched and driven
        gen_addr = 16'h0000;
        gen_r    = 8'h7F;
        gen_din  = 8'h00;
        push_edge(RISE, T1, 1'b0, OP_MEM_WR, OP_FETCH, CTL_IDLE, 8'h00, ST_NONE);
        push_edge(FALL, T1, 1'b0, OP_MEM_WR, OP_FETCH, CTL_IDLE, 8'h00, ST_NONE);
        push_edge(FALL, T2, 1'b0, OP_MEM_WR, OP_FETCH, CTL_IDLE, 8'h00, ST_NONE);
        push_edge(FALL, T3, 1'b0, OP_MEM_WR, OP_FETCH, CTL_IDLE, 8'h00, ST_NONE);
        // io write, then the bus is released while data is driven
        gen_wdata = 8'h00;
        push_edge(RISE, T1, 1'b0, OP_IO_WR, OP_MEM_WR, CTL_IDLE, 8'h00, ST_NONE);
        push_edge(FALL, T1, 1'b0, OP_IO_WR, OP_MEM_WR, CTL_IDLE, 8'h00, ST_NONE);
        push_edge(RISE, T2, 1'b1, OP_IO_WR, OP_MEM_WR, CTL_IDLE, 8'h00, ST_NONE);
        push_edge(RISE, T3, 1'b0, OP_IO_WR, OP_MEM_WR, CTL_GRANT, 8'h00, ST_NONE);
        push_edge(FALL, T3, 1'b0, OP_IO_WR, OP_MEM_WR, CTL_GRANT, 8'h00, ST_NONE);
        push_edge(FALL, T3, 1'b0, OP_IO_WR, OP_MEM_WR, CTL_ACK_ONLY, 8'h00, ST_NONE);
        // reset while released, reclaim, reset alone on a falling edge
        push_edge(RISE, T1, 1'b0, OP_IO_RD, OP_IO_WR, CTL_RESET, 8'h00, ST_NONE);
        push_edge(RISE, T2, 1'b1, OP_IO_RD, OP_IO_WR, CTL_IDLE, 8'h00, ST_NONE);
        gen_din = 8'hFF;
        push_edge(FALL, T3, 1'b0, OP_IO_RD, OP_IO_WR, CTL_RESET, 8'h00, ST_NONE);
        // interrupt acknowledge fetch, HALT released by INT and by NMI
        gen_r = 8'h80;
        push_edge(FALL, T2, 1'b0, OP_FETCH_INT, OP_IO_RD, CTL_IDLE, 8'h00, ST_NONE);
        push_edge(RISE, T3, 1'b0, OP_FETCH_INT, OP_IO_RD, CTL_IDLE, 8'h00, ST_NONE);
        push_edge(FALL, T4, 1'b0, OP_FETCH_INT, OP_IO_RD, CTL_IDLE, 8'h00, ST_INT_ENABLED);
        push_edge(FALL, T4, 1'b0, OP_FETCH, OP_FETCH_INT, CTL_IDLE, HALT_OPCODE, ST_NMI_HALT);
        // unused operation codes and T-states
        push_edge(RISE, T7, 1'b0, OP_UNUSED, OP_UNUSED, CTL_IDLE, 8'hFF, 4'hF);
        push_edge(FALL, T_IDLE, 1'b0, OP_NONE, OP_NONE, CTL_IDLE, 8'h00, ST_NONE);
        push_edge(RISE, T6, 1'b1, OP_MEM_RD, OP_MEM_RD, CTL_IDLE, 8'h00, ST_NONE);
        // memory read sampling zero
        gen_din = 8'h00;
        push_edge(FALL, T3, 1'b0, OP_MEM_RD, OP_MEM_RD, CTL_IDLE, 8'h00, ST_NONE);
        gen_prev = OP_MEM_RD;
    endfunction

    task automatic write_interrupt_page(logic [7:0] page);
        @(negedge clk);
        cfg_write     <= 1'b1;
        cfg_data      <= page;
        modelled_page = page;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Everything sent and every result back, followed by an idle margin
    task automatic wait_bus_idle();
        while (pending_edges.size() != 0 || cycle_if.valid || expected_pin_results.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        logic [7:0] page;
        rst_n           = 1'b0;
        cfg_write       = 1'b0;
        cfg_data        = 8'h00;
        cycle_if.valid  = 1'b0;
        cycle_if.item   = '0;
        result_if.ready = 1'b0;
        modelled_bus    = STATE_RESET;
        modelled_page   = 8'h00;
        gen_prev        = OP_NONE;
        gen_opc         = 8'h00;
        gen_st          = ST_NONE;
        send_pace       = 1;
        recv_pace       = 2;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        write_interrupt_page(8'h5A);
        queue_directed();
        wait_bus_idle();

        // random phases across I register settings, extremes first
        for (int p = 0; p < 4; p++)
        begin
            page = (p == 0) ? 8'hFF : (p == 1) ? 8'h00 : 8'($urandom);
            write_interrupt_page(page);
            queue_random_phase(420);
            wait_bus_idle();
        end
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
